// File: design/prqs_pkg.sv
package prqs_pkg;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_ADD      = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_SCHEDULE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_STARTED     = 3'd1,
        ST_NOT_STARTED = 3'd2,
        ST_FULL_DUP    = 3'd3,
        ST_NOT_QUEUED  = 3'd4
    } t_status;

    localparam int ID_W = 4;

endpackage

// File: design/priority_ready_queue_scheduler_core.sv
// Start, errors and schedules without a switch need no queue memory pass; an add, a
// remove or a switch runs one pass, which reads one entry per cycle, and a second pass
// follows when the old task is requeued.
// Throughput: one item in flight; the next beat is taken once the result is loaded into
// the output register, which holds it under backpressure.
// Reset: synchronous active-low i_rst_n clears queue length, running task and start
// flag; queue memory contents are left undefined and never read unwritten.
module priority_ready_queue_scheduler_core
    import prqs_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation[1:0], task_id[5:2], task_priority[13:6]
    input  logic        s_axis_tuser,  // current_still_running
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // running_task[3:0], running_valid[4], switched[5],
                                       // queue_count[10:6], status[13:11]
);
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int NID = 1 << ID_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEC   = 5'b00010,
        S_EDIT  = 5'b00100,
        S_REINS = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                   r_st, n_st;
    t_op                      r_op;
    logic                     r_still;
    logic [ID_W-1:0]          r_id, n_id;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic                     r_reins, n_reins;   // old task goes back after the pop
    logic [NID-1:0]           r_queued, n_queued; // one bit per task id in the queue
    logic [ID_W-1:0]          r_run, n_run;
    logic [PRIORITY_BITS-1:0] r_runp, n_runp;
    logic                     r_started, n_started;
    logic                     r_sw, n_sw;
    t_status                  r_stat, n_stat;
    logic                     r_ovalid, n_ovalid;
    logic [15:0]              r_odata;
    logic [15:0]              odata;

    logic                     q_start;
    logic                     q_ins;
    logic [ID_W-1:0]          q_id;
    logic [PRIORITY_BITS-1:0] q_prio;
    logic                     q_busy;
    logic [CW-1:0]            q_len;
    logic [ID_W-1:0]          q_head_id;
    logic [PRIORITY_BITS-1:0] q_head_prio;

    logic accept;
    logic out_free;

    // Sorted ready queue lives in the memory engine; one pass per edit.
    prqs_queue #(
        .MAX_TASKS     (MAX_TASKS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CW            (CW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (q_start),
        .i_ins       (q_ins),
        .i_id        (q_id),
        .i_prio      (q_prio),
        .o_busy      (q_busy),
        .o_len       (q_len),
        .o_head_id   (q_head_id),
        .o_head_prio (q_head_prio)
    );

    // Input taken only while idle; the output register decouples the result side.
    assign s_axis_tready = (r_st == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_comb begin
        n_st      = r_st;
        n_id      = r_id;
        n_prio    = r_prio;
        n_reins   = r_reins;
        n_queued  = r_queued;
        n_run     = r_run;
        n_runp    = r_runp;
        n_started = r_started;
        n_sw      = r_sw;
        n_stat    = r_stat;
        n_ovalid  = r_ovalid && !m_axis_tready;
        q_start   = 1'b0;
        q_ins     = 1'b0;
        q_id      = r_id;
        q_prio    = r_prio;
        case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_id    = s_axis_tdata[5:2];
                    n_prio  = PRIORITY_BITS'(s_axis_tdata[13:6]);
                    n_sw    = 1'b0;
                    n_stat  = ST_OK;
                    n_reins = 1'b0;
                    n_st    = S_DEC;
                end
            end
            S_DEC: begin
                // membership comes from the id bitmap, so errors need no memory pass
                n_st = S_DONE;
                case (r_op)
                    OP_START: begin
                        if (r_started) begin
                            n_stat = ST_STARTED;
                        end else begin
                            n_run     = r_id;
                            n_runp    = r_prio;
                            n_started = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (q_len >= CW'(MAX_TASKS) || r_queued[r_id]) begin
                            n_stat = ST_FULL_DUP;
                        end else begin
                            q_start        = 1'b1;
                            q_ins          = 1'b1;
                            n_queued[r_id] = 1'b1;
                            n_st           = S_EDIT;
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_queued[r_id]) begin
                            n_stat = ST_NOT_QUEUED;
                        end else begin
                            q_start        = 1'b1;
                            n_queued[r_id] = 1'b0;
                            n_st           = S_EDIT;
                        end
                    end
                    OP_SCHEDULE: begin
                        if (!r_started) begin
                            n_stat = ST_NOT_STARTED;
                        end else if (q_len != '0 && q_head_id != r_run) begin
                            // pop the head, keep the old task for a possible requeue
                            q_start             = 1'b1;
                            q_id                = q_head_id;
                            n_queued[q_head_id] = 1'b0;
                            n_reins             = r_still && !r_queued[r_run];
                            n_id                = r_run;
                            n_prio              = r_runp;
                            n_run               = q_head_id;
                            n_runp              = q_head_prio;
                            n_sw                = 1'b1;
                            n_st                = S_EDIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_EDIT: begin
                if (!q_busy) begin
                    if (r_reins) begin
                        // room is certain: the pop just freed a slot
                        q_start        = 1'b1;
                        q_ins          = 1'b1;
                        n_queued[r_id] = 1'b1;
                        n_st           = S_REINS;
                    end else begin
                        n_st = S_DONE;
                    end
                end
            end
            S_REINS: begin
                if (!q_busy) n_st = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        odata        = '0;
        odata[3:0]   = r_run;
        odata[4]     = r_started;
        odata[5]     = r_sw;
        odata[10:6]  = 5'(q_len);
        odata[13:11] = r_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_queued  <= '0;
            r_run     <= '0;
            r_runp    <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_queued  <= n_queued;
            r_run     <= n_run;
            r_runp    <= n_runp;
            r_started <= n_started;
            r_ovalid  <= n_ovalid;
        end
        r_id    <= n_id;
        r_prio  <= n_prio;
        r_reins <= n_reins;
        r_sw    <= n_sw;
        r_stat  <= n_stat;
        if (accept) begin
            r_op    <= t_op'(s_axis_tdata[1:0]);
            r_still <= s_axis_tuser;
        end
        if (r_st == S_DONE && out_free) r_odata <= odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Queue never exceeds its depth.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_len <= CW'(MAX_TASKS)) else $error("queue overflow");
    // A stalled result beat holds steady.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");
    // Start flag never drops.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started) else $error("start flag lost");
    // Control state stays one-hot.
    a_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("control state corrupt");
endmodule

// File: design/prqs_queue.sv
module prqs_queue
    import prqs_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int CW            = $clog2(MAX_TASKS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_ins,      // 1 insert by priority, 0 remove by id
    input  logic [ID_W-1:0]          i_id,
    input  logic [PRIORITY_BITS-1:0] i_prio,
    output logic                     o_busy,
    output logic [CW-1:0]            o_len,
    output logic [ID_W-1:0]          o_head_id,
    output logic [PRIORITY_BITS-1:0] o_head_prio
);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int EW = ID_W + PRIORITY_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_qst;

    // Sorted entry memory {id, prio}, one read and one write port, registered read.
    logic [EW-1:0] r_mem [MAX_TASKS];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    t_qst                     r_st, n_st;
    logic [CW-1:0]            r_len, n_len;
    logic [CW-1:0]            r_rpos, n_rpos;   // next address to read
    logic [CW-1:0]            r_dpos, n_dpos;   // position of the entry in r_rd
    logic                     r_ins, n_ins;
    logic                     r_hit, n_hit;
    logic [ID_W-1:0]          r_id, n_id;
    logic [EW-1:0]            r_carry, n_carry;
    logic [ID_W-1:0]          r_hid;
    logic [PRIORITY_BITS-1:0] r_hprio;

    logic [ID_W-1:0]          rd_id;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PRIORITY_BITS-1:0] carry_prio;
    assign rd_id      = r_rd[EW-1 -: ID_W];
    assign rd_prio    = r_rd[PRIORITY_BITS-1:0];
    assign carry_prio = r_carry[PRIORITY_BITS-1:0];

    // One pass walks entries 0..len-1, one per cycle.
    // Insert: past the first lower priority, each entry is pushed down one slot by
    // the carried entry; the last carried entry is appended in S_FIN.
    // Remove: after the matching id, each entry is written one slot up.
    always_comb begin
        n_st    = r_st;
        n_len   = r_len;
        n_rpos  = r_rpos;
        n_dpos  = r_dpos;
        n_ins   = r_ins;
        n_hit   = r_hit;
        n_id    = r_id;
        n_carry = r_carry;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_carry;
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    // entry 0 is read this cycle
                    n_ins   = i_ins;
                    n_id    = i_id;
                    n_carry = {i_id, i_prio};
                    n_hit   = 1'b0;
                    n_dpos  = '0;
                    n_rpos  = CW'(1);
                    n_st    = (r_len != '0) ? S_RUN : S_FIN;
                end
            end
            S_RUN: begin
                if (r_ins) begin
                    if (r_hit || rd_prio < carry_prio) begin
                        wr_en   = 1'b1;
                        wr_addr = r_dpos[AW-1:0];
                        wr_data = r_carry;
                        n_carry = r_rd;
                        n_hit   = 1'b1;
                    end
                end else begin
                    if (r_hit) begin
                        wr_en   = 1'b1;
                        wr_addr = r_dpos[AW-1:0] - AW'(1);
                        wr_data = r_rd;
                    end
                    if (rd_id == r_id) n_hit = 1'b1;
                end
                if (r_rpos < r_len) begin
                    rd_addr = r_rpos[AW-1:0];
                    n_dpos  = r_rpos;
                    n_rpos  = r_rpos + CW'(1);
                end else begin
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                if (r_ins) begin
                    wr_en   = 1'b1;
                    wr_addr = r_len[AW-1:0];
                    wr_data = r_carry;
                    n_len   = r_len + CW'(1);
                end else if (r_hit) begin
                    n_len = r_len - CW'(1);
                end
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_len <= '0;
        end else begin
            r_st  <= n_st;
            r_len <= n_len;
        end
        r_rpos  <= n_rpos;
        r_dpos  <= n_dpos;
        r_ins   <= n_ins;
        r_hit   <= n_hit;
        r_id    <= n_id;
        r_carry <= n_carry;
        // head mirror: every change of entry 0 goes through the write port
        if (wr_en && wr_addr == '0) begin
            r_hid   <= wr_data[EW-1 -: ID_W];
            r_hprio <= wr_data[PRIORITY_BITS-1:0];
        end
    end

    assign o_busy      = (r_st != S_IDLE);
    assign o_len       = r_len;
    assign o_head_id   = r_hid;
    assign o_head_prio = r_hprio;
endmodule
